>>> hw/rtl/bfsp_pkg.sv
// Shared constants and types for the shortest path core.
package bfsp_pkg;

  localparam int MAX_NODES_DEF   = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam logic [4:0] NODE_COUNT_RST = 5'd16;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_SOURCE     = 1'b1
  } cfg_index_t;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_INIT   = 6'b000100,
    ST_RUN    = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  typedef struct packed {
    logic init;
    logic check;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/bfsp_ram.sv
// Generic simple dual-port RAM with registered read.
module bfsp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bfsp_cell.sv
// One vertex cell: holds its distance and its weight column, relaxes passing tokens.
module bfsp_cell #(
  parameter int K           = 0,
  parameter int MAX_NODES   = bfsp_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF,
  parameter int AW          = 4,
  parameter int NW          = 5,
  parameter int DW          = 30
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bfsp_pkg::cell_ctrl_t   ctrl,
  input  logic [NW-1:0]          node_cnt,
  input  logic [3:0]             src_vertex,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [WEIGHT_BITS:0]   wr_data,
  input  logic                   tok_vld_i,
  input  logic [AW-1:0]          tok_u_i,
  input  logic signed [DW-1:0]   tok_du_i,
  output logic                   tok_vld_o,
  output logic [AW-1:0]          tok_u_o,
  output logic signed [DW-1:0]   tok_du_o,
  output logic                   dist_vld_o,
  output logic signed [DW-1:0]   dist_o,
  output logic                   hit_o
);

  logic                          tok_vld_r;
  logic [AW-1:0]                 tok_u_r;
  logic signed [DW-1:0]          tok_du_r;
  logic                          dist_vld_r;
  logic signed [DW-1:0]          dist_r;
  logic [WEIGHT_BITS:0]          w_rd;
  logic signed [WEIGHT_BITS-1:0] w_val;
  logic signed [DW-1:0]          cand;
  logic                          active;
  logic                          relax;

  bfsp_ram #(
    .WIDTH (WEIGHT_BITS + 1),
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_col (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (tok_u_i),
    .rdata (w_rd)
  );

  assign w_val  = w_rd[WEIGHT_BITS-1:0];
  assign cand   = tok_du_r + DW'(w_val);
  assign active = 32'(node_cnt) > K;
  assign relax  = tok_vld_r && w_rd[WEIGHT_BITS] && active && (!dist_vld_r || cand < dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r  <= 1'b0;
      dist_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
      if (ctrl.init) begin
        dist_vld_r <= (32'(src_vertex) == K) && (32'(src_vertex) < 32'(node_cnt));
      end else if (relax && !ctrl.check) begin
        dist_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_u_r  <= tok_u_i;
    tok_du_r <= tok_du_i;
    if (ctrl.init) begin
      dist_r <= '0;
    end else if (relax && !ctrl.check) begin
      dist_r <= cand;
    end
  end

  assign tok_vld_o  = tok_vld_r;
  assign tok_u_o    = tok_u_r;
  assign tok_du_o   = tok_du_r;
  assign dist_vld_o = dist_vld_r;
  assign dist_o     = dist_r;
  assign hit_o      = relax && ctrl.check;

endmodule

>>> hw/rtl/bellman_ford_shortest_paths_core.sv
// Top level: control sequencer and the chain of vertex cells.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+--------------------------------
//  input    | start/busy, in_*              | taken when start & !busy
//  config   | cfg_valid/cfg_ready, cfg_*    | taken when cfg_valid & cfg_ready
//  result   | out_strobe, out_*             | strobe per result, no stall
//
// Matrix entries are taken while the core is idle. The entry marked last starts a run
// of n-1 relaxation passes plus one check pass; each pass issues a token for each
// of the n vertices with a known distance into the cell chain and then drains it,
// and the run is followed by n results (one on a cycle hit).
// After reset a clearing pass over all MAX_NODES row addresses empties the weight columns.
module bellman_ford_shortest_paths_core #(
  parameter int MAX_NODES   = bfsp_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_row_index,
  input  logic [3:0]         in_col_index,
  input  logic signed [15:0] in_edge_weight,
  input  logic               in_edge_present,
  input  logic               in_last_entry,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_wdata,
  output logic               out_strobe,
  output logic [3:0]         out_vertex_id,
  output logic signed [31:0] out_distance,
  output logic               out_reachable,
  output logic               out_negative_cycle,
  output logic               out_last_result
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int DW = WEIGHT_BITS + 3 * AW + 2;

  bfsp_pkg::state_t     state_r;
  bfsp_pkg::cell_ctrl_t cell_ctrl;

  logic [4:0]    node_count_r;
  logic [3:0]    src_r;
  logic [AW:0]   cnt_r;
  logic [AW-1:0] u_r;
  logic [AW-1:0] pass_r;
  logic          check_r;
  logic          cyc_r;

  logic          out_strobe_r;
  logic [3:0]    out_vertex_r;
  logic [31:0]   out_dist_r;
  logic          out_reach_r;
  logic          out_neg_r;
  logic          out_last_r;

  logic [31:0]   nc_ext;
  logic [31:0]   n_eff32;
  logic [NW-1:0] n_eff;
  logic [AW-1:0] nm1;

  logic                  ld_en;
  logic [AW-1:0]         wr_addr;
  logic [WEIGHT_BITS:0]  wr_data;
  logic [31:0]           row_ext;
  logic [31:0]           col_ext;

  logic                 tok_vld_a [MAX_NODES+1];
  logic [AW-1:0]        tok_u_a   [MAX_NODES+1];
  logic signed [DW-1:0] tok_du_a  [MAX_NODES+1];
  logic                 dist_vld_a [MAX_NODES];
  logic signed [DW-1:0] dist_a     [MAX_NODES];
  logic [MAX_NODES-1:0] hit_a;

  assign nc_ext  = 32'(node_count_r);
  assign n_eff32 = (nc_ext == 0) ? 32'd1 :
                   (nc_ext > MAX_NODES) ? 32'(MAX_NODES) : nc_ext;
  assign n_eff   = NW'(n_eff32);
  assign nm1     = AW'(n_eff32 - 32'd1);

  assign busy      = (state_r != bfsp_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign row_ext = 32'(in_row_index);
  assign col_ext = 32'(in_col_index);
  assign ld_en   = start && !busy && (row_ext < MAX_NODES) && (col_ext < MAX_NODES);
  assign wr_addr = (state_r == bfsp_pkg::ST_CLEAR) ? cnt_r[AW-1:0] : row_ext[AW-1:0];
  assign wr_data = (state_r == bfsp_pkg::ST_CLEAR) ? '0 :
                   {in_edge_present, WEIGHT_BITS'(in_edge_weight)};

  assign cell_ctrl.init  = (state_r == bfsp_pkg::ST_INIT);
  assign cell_ctrl.check = check_r;

  // Issue the distance of vertex u into the head of the chain.
  assign tok_vld_a[0] = (state_r == bfsp_pkg::ST_RUN) && dist_vld_a[u_r];
  assign tok_u_a[0]   = u_r;
  assign tok_du_a[0]  = dist_a[u_r];

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    bfsp_cell #(
      .K           (k),
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .AW          (AW),
      .NW          (NW),
      .DW          (DW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .node_cnt   (n_eff),
      .src_vertex (src_r),
      .wr_en      ((state_r == bfsp_pkg::ST_CLEAR) ||
                   (ld_en && (col_ext[AW-1:0] == AW'(k)))),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .tok_vld_i  (tok_vld_a[k]),
      .tok_u_i    (tok_u_a[k]),
      .tok_du_i   (tok_du_a[k]),
      .tok_vld_o  (tok_vld_a[k+1]),
      .tok_u_o    (tok_u_a[k+1]),
      .tok_du_o   (tok_du_a[k+1]),
      .dist_vld_o (dist_vld_a[k]),
      .dist_o     (dist_a[k]),
      .hit_o      (hit_a[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfsp_pkg::ST_CLEAR;
      node_count_r <= bfsp_pkg::NODE_COUNT_RST;
      src_r        <= '0;
      cnt_r        <= '0;
      u_r          <= '0;
      pass_r       <= '0;
      check_r      <= 1'b0;
      cyc_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (bfsp_pkg::cfg_index_t'(cfg_index))
          bfsp_pkg::CFG_NODE_COUNT: node_count_r <= cfg_wdata;
          bfsp_pkg::CFG_SOURCE:     src_r        <= cfg_wdata[3:0];
        endcase
      end
      out_strobe_r <= (state_r == bfsp_pkg::ST_RESULT);
      cyc_r        <= (state_r == bfsp_pkg::ST_INIT) ? 1'b0 : (cyc_r | (|hit_a));
      unique case (state_r)
        bfsp_pkg::ST_CLEAR: begin
          if (cnt_r == (AW+1)'(MAX_NODES - 1)) begin
            cnt_r   <= '0;
            state_r <= bfsp_pkg::ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        bfsp_pkg::ST_IDLE: begin
          if (start && in_last_entry) begin
            state_r <= bfsp_pkg::ST_INIT;
          end
        end
        bfsp_pkg::ST_INIT: begin
          u_r     <= '0;
          pass_r  <= '0;
          check_r <= (n_eff32 == 32'd1);
          state_r <= bfsp_pkg::ST_RUN;
        end
        bfsp_pkg::ST_RUN: begin
          if (u_r == nm1) begin
            u_r     <= '0;
            cnt_r   <= '0;
            state_r <= bfsp_pkg::ST_DRAIN;
          end else begin
            u_r <= u_r + 1'b1;
          end
        end
        bfsp_pkg::ST_DRAIN: begin
          // wait until the last token has left the chain
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (AW+1)'(MAX_NODES)) begin
            if (check_r) begin
              state_r <= bfsp_pkg::ST_RESULT;
            end else begin
              if (pass_r == nm1 - 1'b1) begin
                check_r <= 1'b1;
              end else begin
                pass_r <= pass_r + 1'b1;
              end
              state_r <= bfsp_pkg::ST_RUN;
            end
          end
        end
        bfsp_pkg::ST_RESULT: begin
          if (cyc_r) begin
            out_vertex_r <= '0;
            out_dist_r   <= '0;
            out_reach_r  <= 1'b0;
            out_neg_r    <= 1'b1;
            out_last_r   <= 1'b1;
            check_r      <= 1'b0;
            state_r      <= bfsp_pkg::ST_IDLE;
          end else begin
            out_vertex_r <= 4'(u_r);
            out_dist_r   <= dist_vld_a[u_r] ? 32'(dist_a[u_r]) : 32'd0;
            out_reach_r  <= dist_vld_a[u_r];
            out_neg_r    <= 1'b0;
            out_last_r   <= (u_r == nm1);
            if (u_r == nm1) begin
              u_r     <= '0;
              check_r <= 1'b0;
              state_r <= bfsp_pkg::ST_IDLE;
            end else begin
              u_r <= u_r + 1'b1;
            end
          end
        end
        default: state_r <= bfsp_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_vertex_id      = out_vertex_r;
  assign out_distance       = out_dist_r;
  assign out_reachable      = out_reach_r;
  assign out_negative_cycle = out_neg_r;
  assign out_last_result    = out_last_r;

endmodule

>>> sim/bellman_ford_shortest_paths_core_tb.sv
// Self-checking regression for the shortest path core: directed and random graphs.
module bellman_ford_shortest_paths_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  vertex_id;
    logic [31:0] distance;
    logic        reachable;
    logic        negative_cycle;
    logic        last_result;
  } path_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_row_index = '0;
  logic [3:0] in_col_index = '0;
  logic signed [15:0] in_edge_weight = '0;
  logic in_edge_present = 1'b0;
  logic in_last_entry = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic out_strobe;
  logic [3:0] out_vertex_id;
  logic signed [31:0] out_distance;
  logic out_reachable;
  logic out_negative_cycle;
  logic out_last_result;

  bit edge_exists [256];
  longint edge_cost [256];
  int unsigned vertex_limit = 16;
  int unsigned origin = 0;
  path_result_t pending_paths[$];
  int error_count = 0;
  int entries_sent = 0;
  int runs_done = 0;
  int cycles_seen = 0;
  int results_seen = 0;

  always #6 clk = ~clk;

  bellman_ford_shortest_paths_core u_dut (.*);

  // Apply one matrix entry to the shadow store; on the last entry, solve the graph.
  task automatic solve_paths(input logic [3:0] r, input logic [3:0] c,
                             input logic [15:0] w, input logic p, input logic l);
    int unsigned n;
    bit known [16];
    longint path_len [16];
    bit cycle;
    path_result_t res;
    longint cand;
    int idx;
    idx = r * 16 + c;
    edge_exists[idx] = p;
    edge_cost[idx] = longint'(signed'(w));
    if (!l) return;
    n = vertex_limit == 0 ? 1 : (vertex_limit > 16 ? 16 : vertex_limit);
    for (int v = 0; v < 16; v++) begin
      known[v] = 0;
      path_len[v] = 0;
    end
    if (origin < n) known[origin] = 1;
    for (int k = 0; k + 1 < n; k++)
      for (int u = 0; u < n; u++)
        for (int v = 0; v < n; v++)
          if (edge_exists[u*16+v] && known[u]) begin
            cand = path_len[u] + edge_cost[u*16+v];
            if (!known[v] || cand < path_len[v]) begin
              path_len[v] = cand;
              known[v] = 1;
            end
          end
    cycle = 0;
    for (int u = 0; u < n; u++)
      for (int v = 0; v < n; v++)
        if (edge_exists[u*16+v] && known[u] &&
            (!known[v] || path_len[u] + edge_cost[u*16+v] < path_len[v]))
          cycle = 1;
    if (cycle) begin
      res = '{vertex_id: 4'd0, distance: 32'd0, reachable: 1'b0,
              negative_cycle: 1'b1, last_result: 1'b1};
      pending_paths.push_back(res);
    end else begin
      for (int v = 0; v < n; v++) begin
        res.vertex_id = v[3:0];
        res.distance = known[v] ? path_len[v][31:0] : 32'd0;
        res.reachable = known[v];
        res.negative_cycle = 1'b0;
        res.last_result = (v + 1 == n);
        pending_paths.push_back(res);
      end
    end
    runs_done++;
  endtask

  // Send one matrix entry; hold start until the transaction is taken.
  task automatic send_entry(input logic [3:0] r, input logic [3:0] c,
                            input logic [15:0] w, input logic p, input logic l);
    start <= 1'b1;
    in_row_index <= r;
    in_col_index <= c;
    in_edge_weight <= w;
    in_edge_present <= p;
    in_last_entry <= l;
    do @(posedge clk); while (busy);
    solve_paths(r, c, w, p, l);
    entries_sent++;
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Leave valid high; the caller drops it after its last write.
  task automatic write_reg(input bfsp_pkg::cfg_index_t which, input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    if (which == bfsp_pkg::CFG_NODE_COUNT) vertex_limit = value;
    else origin = value[3:0];
  endtask

  task automatic set_graph(input logic [4:0] n, input logic [3:0] src);
    drain_results();
    write_reg(bfsp_pkg::CFG_NODE_COUNT, n);
    write_reg(bfsp_pkg::CFG_SOURCE, src);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    path_result_t got, want;
    if (rst_n && out_strobe) begin
      got = '{out_vertex_id, out_distance, out_reachable, out_negative_cycle,
              out_last_result};
      results_seen++;
      if (got.negative_cycle) cycles_seen++;
      if (pending_paths.size() == 0) begin
        $error("unexpected result vertex %0d", got.vertex_id);
        error_count++;
      end else begin
        want = pending_paths.pop_front();
        if (got.vertex_id != want.vertex_id) begin
          $error("vertex_id exp %0d got %0d", want.vertex_id, got.vertex_id);
          error_count++;
        end
        if (got.distance != want.distance) begin
          $error("distance exp %0d got %0d", $signed(want.distance), $signed(got.distance));
          error_count++;
        end
        if (got.reachable != want.reachable) begin
          $error("reachable exp %0b got %0b", want.reachable, got.reachable);
          error_count++;
        end
        if (got.negative_cycle != want.negative_cycle) begin
          $error("negative_cycle exp %0b got %0b", want.negative_cycle, got.negative_cycle);
          error_count++;
        end
        if (got.last_result != want.last_result) begin
          $error("last_result exp %0b got %0b", want.last_result, got.last_result);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    // Default config: single last entry on an empty graph, source 0 of 16.
    send_entry(4'd15, 4'd15, 16'h7fff, 1'b0, 1'b1);
    set_graph(5'd4, 4'd0);
    send_entry(4'd0, 4'd1, 16'h8000, 1'b1, 1'b0);
    send_entry(4'd1, 4'd2, 16'h7fff, 1'b1, 1'b0);
    send_entry(4'd2, 4'd3, 16'd5, 1'b1, 1'b1);
    // Close a positive-weight loop through vertices 1, 2 and 3, then open it again.
    send_entry(4'd3, 4'd1, 16'hffff, 1'b1, 1'b1);
    send_entry(4'd3, 4'd1, 16'hffff, 1'b0, 1'b1);
    // Source outside the vertices in use.
    set_graph(5'd2, 4'd15);
    send_entry(4'd0, 4'd1, 16'd3, 1'b1, 1'b1);
    set_graph(5'd0, 4'd0);
    send_entry(4'd0, 4'd0, 16'd0, 1'b1, 1'b1);
    set_graph(5'd31, 4'd3);
    send_entry(4'd15, 4'd0, 16'hfff0, 1'b1, 1'b1);
    set_graph(5'd1, 4'd0);
    send_entry(4'd0, 4'd0, 16'hffff, 1'b1, 1'b1);
    send_entry(4'd0, 4'd0, 16'hffff, 1'b0, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    logic [4:0] n;
    sent = 0;
    while (sent < 100) begin
      n = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(9, 31)) : 5'($urandom_range(1, 6));
      set_graph(n, 4'($urandom_range(0, n < 16 ? n : 15)));
      repeat ($urandom_range(2, 10)) begin
        // Mostly nonnegative weights so some runs reach full distance lists.
        send_entry(4'($urandom_range(0, n < 16 ? n : 15)), 4'($urandom),
                   $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200)),
                   $urandom_range(0, 2) != 0, 1'b0);
        sent++;
      end
      send_entry(4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom), 1'b1);
      sent++;
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      edge_exists[i] = 0;
      edge_cost[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain_results();
    if (pending_paths.size() != 0) error_count++;
    $display("covered %0d entries, %0d runs, %0d results, %0d negative cycles",
             entries_sent, runs_done, results_seen, cycles_seen);
    if (error_count == 0) $display("bellman_ford_shortest_paths_core regression: pass");
    else $display("bellman_ford_shortest_paths_core regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("bellman_ford_shortest_paths_core regression: fail");
    $finish;
  end
endmodule
